// ----- rtl/bnsp_pkg.sv -----
`default_nettype none

package bnsp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIST_W          = 64;
  localparam int FACE_W          = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int PIPE_DEPTH      = 7;

  localparam logic [63:0] BOX_MIN_RESET = 64'd0;
  localparam logic [63:0] BOX_MAX_RESET = 64'd65536;

  localparam logic [FACE_W-1:0] FACE_MISS = 3'd6;

  localparam logic REQ_FACE = 1'b0;
  localparam logic REQ_EDGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

  typedef logic [1:0] axis_idx_t;

  localparam axis_idx_t AXIS_X = 2'd0;
  localparam axis_idx_t AXIS_Y = 2'd1;
  localparam axis_idx_t AXIS_Z = 2'd2;

  typedef struct packed {
    logic clamped;   // sample lay outside the slab on this axis
    logic wall_lo;   // chosen wall coordinate equals the min bound
  } axis_flags_t;

  function automatic logic [FACE_W-1:0] face_code(axis_idx_t ax, logic wall_lo);
    face_code = {ax, ~wall_lo};
  endfunction

  function automatic logic [DIST_W-1:0] sat_add(logic [DIST_W-1:0] a,
                                                logic [DIST_W-1:0] b);
    logic [DIST_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bnsp_axis.sv -----
`default_nettype none

module bnsp_axis import bnsp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [COORD_WIDTH-1:0] sample,
  input  wire logic [COORD_WIDTH-1:0] box_lo,
  input  wire logic [COORD_WIDTH-1:0] box_hi,
  output logic      [COORD_WIDTH-1:0] s_q,
  output logic      [COORD_WIDTH-1:0] wall_q,
  output logic      [COORD_WIDTH-1:0] d_q,
  output axis_flags_t                 flags_q
);

  localparam int SW = COORD_WIDTH + 2;
  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] s_sg;
  logic signed [COORD_WIDTH-1:0] lo_sg;
  logic signed [COORD_WIDTH-1:0] hi_sg;
  logic signed [SW-1:0]          twice_s;
  logic signed [SW-1:0]          bound_sum;
  logic                          below;
  logic                          above;
  logic                          upper;
  logic                          flat;
  logic [COORD_WIDTH-1:0]        wall_next;
  axis_flags_t                   flags_next;

  logic [COORD_WIDTH-1:0]        s1;
  logic [COORD_WIDTH-1:0]        wall1;
  axis_flags_t                   flags1;

  logic signed [DW-1:0]          diff;
  logic [COORD_WIDTH-1:0]        d_next;

  assign s_sg      = signed'(sample);
  assign lo_sg     = signed'(box_lo);
  assign hi_sg     = signed'(box_hi);
  // midpoint test done exactly as 2*s > lo+hi
  assign twice_s   = {s_sg[COORD_WIDTH-1], s_sg, 1'b0};
  assign bound_sum = SW'(lo_sg) + SW'(hi_sg);
  assign below     = s_sg < lo_sg;
  assign above     = s_sg > hi_sg;
  assign upper     = twice_s > bound_sum;
  assign flat      = box_lo == box_hi;

  always_comb begin
    flags_next = '0;
    if (below) begin
      wall_next          = box_lo;
      flags_next.clamped = 1'b1;
      flags_next.wall_lo = 1'b1;
    end else if (above) begin
      wall_next          = box_hi;
      flags_next.clamped = 1'b1;
      flags_next.wall_lo = flat;
    end else if (upper) begin
      wall_next          = box_hi;
      flags_next.wall_lo = flat;
    end else begin
      wall_next          = box_lo;
      flags_next.wall_lo = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1     <= sample;
      wall1  <= wall_next;
      flags1 <= flags_next;
    end
  end

  assign diff   = DW'(signed'(s1)) - DW'(signed'(wall1));
  assign d_next = diff[DW-1] ? COORD_WIDTH'(-diff) : COORD_WIDTH'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      s_q     <= s1;
      wall_q  <= wall1;
      d_q     <= d_next;
      flags_q <= flags1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bnsp_select.sv -----
`default_nettype none

module bnsp_select import bnsp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic                         req_type,
  input  wire logic [2:0][COORD_WIDTH-1:0]  s,
  input  wire logic [2:0][COORD_WIDTH-1:0]  wall,
  input  wire logic [2:0][COORD_WIDTH-1:0]  d,
  input  wire axis_flags_t [2:0]            flags,
  output logic      [2:0][COORD_WIDTH-1:0]  p_q,
  output logic      [2:0][COORD_WIDTH-1:0]  m_q,
  output logic      [FACE_W-1:0]            face_q
);

  logic       ge10;
  logic       ge20;
  logic       ge21;
  logic       lt01;
  logic       lt02;
  logic       lt12;
  logic [2:0] clamped;
  logic [2:0] mask;
  axis_idx_t  fax;

  assign ge10    = d[1] >= d[0];
  assign ge20    = d[2] >= d[0];
  assign ge21    = d[2] >= d[1];
  assign lt01    = d[0] < d[1];
  assign lt02    = d[0] < d[2];
  assign lt12    = d[1] < d[2];
  assign clamped = {flags[2].clamped, flags[1].clamped, flags[0].clamped};

  always_comb begin
    if (|clamped) begin
      // outside: clamp every offending axis, report the last one
      mask = clamped;
      if (clamped[2]) begin
        fax = AXIS_Z;
      end else if (clamped[1]) begin
        fax = AXIS_Y;
      end else begin
        fax = AXIS_X;
      end
    end else if (req_type == REQ_FACE) begin
      if (lt01 && lt02) begin
        fax = AXIS_X;
      end else if (!lt01 && lt12) begin
        fax = AXIS_Y;
      end else begin
        fax = AXIS_Z;
      end
      mask = 3'(3'b001 << fax);
    end else begin
      // drop the farthest wall (ties go to the later axis), face of the nearer-sorted second
      if (ge20 && ge21) begin
        mask = 3'b011;
        fax  = ge10 ? AXIS_Y : AXIS_X;
      end else if (ge10) begin
        mask = 3'b101;
        fax  = ge20 ? AXIS_Z : AXIS_X;
      end else begin
        mask = 3'b110;
        fax  = ge21 ? AXIS_Z : AXIS_Y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= mask[i] ? wall[i] : s[i];
        m_q[i] <= mask[i] ? d[i] : '0;
      end
      face_q <= face_code(fax, flags[fax].wall_lo);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bnsp_dist.sv -----
`default_nettype none

module bnsp_dist import bnsp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [2:0][COORD_WIDTH-1:0]  p,
  input  wire logic [2:0][COORD_WIDTH-1:0]  m,
  input  wire logic [FACE_W-1:0]            face_in,
  input  wire logic [DIST_W-1:0]            limit,
  output logic                              hit,
  output logic      [FACE_W-1:0]            face,
  output logic      [2:0][COORD_WIDTH-1:0]  near
);

  logic [2:0][DIST_W-1:0]      m_ext;
  logic [2:0][DIST_W-1:0]      sq_next;

  logic [2:0][DIST_W-1:0]      sq;
  logic [2:0][COORD_WIDTH-1:0] p4;
  logic [FACE_W-1:0]           face4;
  logic [DIST_W-1:0]           limit4;

  logic [DIST_W-1:0]           sum01;
  logic [DIST_W-1:0]           sq2_5;
  logic [2:0][COORD_WIDTH-1:0] p5;
  logic [FACE_W-1:0]           face5;
  logic [DIST_W-1:0]           limit5;

  logic [DIST_W-1:0]           total;
  logic [2:0][COORD_WIDTH-1:0] p6;
  logic [FACE_W-1:0]           face6;
  logic [DIST_W-1:0]           limit6;

  logic                        hit_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_ext[i]   = DIST_W'(m[i]);
      // saturate once the difference reaches 2^32
      sq_next[i] = (|m_ext[i][63:32]) ? '1 : m_ext[i][31:0] * m_ext[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq     <= sq_next;
      p4     <= p;
      face4  <= face_in;
      limit4 <= limit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum01  <= sat_add(sq[0], sq[1]);
      sq2_5  <= sq[2];
      p5     <= p4;
      face5  <= face4;
      limit5 <= limit4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total  <= sat_add(sum01, sq2_5);
      p6     <= p5;
      face6  <= face5;
      limit6 <= limit5;
    end
  end

  assign hit_next = total <= limit6;

  always_ff @(posedge clk) begin
    if (en) begin
      hit  <= hit_next;
      face <= hit_next ? face6 : FACE_MISS;
      near <= p6;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/box_nearest_surface_point_unit.sv -----
// An accepted request passes the axis, select and distance stages before its result reaches the output registers.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds in place while a finished result is stalled at the output.
// Reset (synchronous, active high) clears all pipeline valid bits and loads the box
// registers with min 0.0 and max 1.0 on every axis.
`default_nettype none

module box_nearest_surface_point_unit import bnsp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          req_type,
  input  wire logic signed [COORD_WIDTH-1:0] sample_x,
  input  wire logic signed [COORD_WIDTH-1:0] sample_y,
  input  wire logic signed [COORD_WIDTH-1:0] sample_z,
  input  wire logic [DIST_W-1:0]             max_dist_sq,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic                               hit,
  output logic      [FACE_W-1:0]             face,
  output logic signed [COORD_WIDTH-1:0]      near_x,
  output logic signed [COORD_WIDTH-1:0]      near_y,
  output logic signed [COORD_WIDTH-1:0]      near_z
);

  localparam logic [COORD_WIDTH-1:0] LO_RST = COORD_WIDTH'(BOX_MIN_RESET);
  localparam logic [COORD_WIDTH-1:0] HI_RST = COORD_WIDTH'(BOX_MAX_RESET);

  logic [2:0][COORD_WIDTH-1:0] box_lo;
  logic [2:0][COORD_WIDTH-1:0] box_hi;

  logic                        advance;
  logic [PIPE_DEPTH-1:0]       vld;

  logic [2:0][COORD_WIDTH-1:0] sample;
  logic [2:0][COORD_WIDTH-1:0] s2;
  logic [2:0][COORD_WIDTH-1:0] wall2;
  logic [2:0][COORD_WIDTH-1:0] d2;
  axis_flags_t [2:0]           flags2;

  logic                        type1;
  logic                        type2;
  logic [DIST_W-1:0]           limit1;
  logic [DIST_W-1:0]           limit2;
  logic [DIST_W-1:0]           limit3;

  logic [2:0][COORD_WIDTH-1:0] p3;
  logic [2:0][COORD_WIDTH-1:0] m3;
  logic [FACE_W-1:0]           face3;
  logic [2:0][COORD_WIDTH-1:0] near;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo <= {3{LO_RST}};
      box_hi <= {3{HI_RST}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_X: box_lo[0] <= cfg_data;
        CFG_MIN_Y: box_lo[1] <= cfg_data;
        CFG_MIN_Z: box_lo[2] <= cfg_data;
        CFG_MAX_X: box_hi[0] <= cfg_data;
        CFG_MAX_Y: box_hi[1] <= cfg_data;
        CFG_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold every stage while the output result is stalled
  assign advance   = !(vld[PIPE_DEPTH-1] && res_stall);
  assign req_stall = !advance;
  assign res_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_DEPTH-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      type1  <= req_type;
      type2  <= type1;
      limit1 <= max_dist_sq;
      limit2 <= limit1;
      limit3 <= limit2;
    end
  end

  assign sample = {sample_z, sample_y, sample_x};

  for (genvar a = 0; a < 3; a++) begin : g_axis
    bnsp_axis #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_axis (
      .clk     (clk),
      .en      (advance),
      .sample  (sample[a]),
      .box_lo  (box_lo[a]),
      .box_hi  (box_hi[a]),
      .s_q     (s2[a]),
      .wall_q  (wall2[a]),
      .d_q     (d2[a]),
      .flags_q (flags2[a])
    );
  end

  bnsp_select #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_select (
    .clk      (clk),
    .en       (advance),
    .req_type (type2),
    .s        (s2),
    .wall     (wall2),
    .d        (d2),
    .flags    (flags2),
    .p_q      (p3),
    .m_q      (m3),
    .face_q   (face3)
  );

  bnsp_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk     (clk),
    .en      (advance),
    .p       (p3),
    .m       (m3),
    .face_in (face3),
    .limit   (limit3),
    .hit     (hit),
    .face    (face),
    .near    (near)
  );

  assign near_x = signed'(near[0]);
  assign near_y = signed'(near[1]);
  assign near_z = signed'(near[2]);

`ifndef SYNTHESIS
  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && !hit |-> face == FACE_MISS)
    else $error("miss result without miss face code");

  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && hit |-> face != FACE_MISS && face != 3'd7)
    else $error("hit result with invalid face code");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled without output back-pressure");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    $past(req_stall) && !$past(rst) |-> $stable(vld))
    else $error("pipeline valid bits moved during a stall");
`endif

endmodule

`default_nettype wire
